FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the console engine RTL
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in every cycle in which ante holds
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// cond must never hold
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, codes and defaults of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // field widths of the channels
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 2 * COLOR_W;
    localparam int COL_PORT_W = 7;
    localparam int ROW_PORT_W = 5;
    localparam int CELL_W     = ATTR_W + CHAR_W;

    // defaults of the top level parameters
    localparam int DEF_COLUMNS     = 80;
    localparam int DEF_ROWS        = 25;
    localparam int DEF_TAB_STOP    = 8;
    localparam int DEF_QUEUE_DEPTH = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_SET   = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
    localparam logic [CHAR_W-1:0] CH_VT      = 8'd11;
    localparam logic [CHAR_W-1:0] CH_FF      = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

    // operation classes handed from the front end to the back end
    typedef enum logic [3:0] {
        OP_GLYPH     = 4'd0,
        OP_BACKSPACE = 4'd1,
        OP_DOWN      = 4'd2,
        OP_TAB       = 4'd3,
        OP_NEWLINE   = 4'd4,
        OP_RETURN    = 4'd5,
        OP_CLEAR     = 4'd6,
        OP_SET       = 4'd7,
        OP_READ      = 4'd8
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [CHAR_W-1:0]   glyph;
        logic [ATTR_W-1:0]   attr;
    } op_head_t;

endpackage

FILE: rtl/core/tcce_cmd_if.sv
// ----------------------------------------------------------------------------
// tcce_cmd_if
// Command channel: one console operation per transaction.
// ----------------------------------------------------------------------------
interface tcce_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [tcce_pkg::FUNC_W-1:0]      func;
    logic [tcce_pkg::CHAR_W-1:0]      char_code;
    logic [tcce_pkg::COLOR_W-1:0]     back_color;
    logic [tcce_pkg::COLOR_W-1:0]     fore_color;
    logic [tcce_pkg::COL_PORT_W-1:0]  col;
    logic [tcce_pkg::ROW_PORT_W-1:0]  row;

    modport source (
        output valid, func, char_code, back_color, fore_color, col, row,
        input  ready
    );

    modport sink (
        input  valid, func, char_code, back_color, fore_color, col, row,
        output ready
    );
endinterface

FILE: rtl/core/tcce_rsp_if.sv
// ----------------------------------------------------------------------------
// tcce_rsp_if
// Response channel: one result per operation.
// ----------------------------------------------------------------------------
interface tcce_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [tcce_pkg::CELL_W-1:0]      cell_data;
    logic [tcce_pkg::COL_PORT_W-1:0]  cursor_col;
    logic [tcce_pkg::ROW_PORT_W-1:0]  cursor_row;
    logic                             scrolled;

    modport source (
        output valid, cell_data, cursor_col, cursor_row, scrolled,
        input  ready
    );

    modport sink (
        input  valid, cell_data, cursor_col, cursor_row, scrolled,
        output ready
    );
endinterface

FILE: rtl/core/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = tcce_pkg::CELL_W,
    parameter int DEPTH = tcce_pkg::DEF_COLUMNS * tcce_pkg::DEF_ROWS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/tcce_front.sv
// ----------------------------------------------------------------------------
// tcce_front
// Takes command transactions, decodes them into operation classes and clamps
// the coordinates to the screen.
// ----------------------------------------------------------------------------
module tcce_front #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS)
) (
    tcce_cmd_if.sink cmd,
    output logic     push_valid,
    input  logic     push_ready,
    output logic [$bits(tcce_pkg::op_head_t)+COL_W+ROW_W-1:0] push_data
);

    tcce_pkg::op_head_t head;
    logic [COL_W-1:0]   col_c;
    logic [ROW_W-1:0]   row_c;

    always_comb
    begin
        head.glyph = cmd.char_code;
        head.attr  = {cmd.back_color, cmd.fore_color};
        head.kind  = tcce_pkg::OP_GLYPH;
        unique case (cmd.func)
            tcce_pkg::FUNC_PUT:
            begin
                unique case (cmd.char_code) inside
                    tcce_pkg::CH_BS:                  head.kind = tcce_pkg::OP_BACKSPACE;
                    tcce_pkg::CH_VT, tcce_pkg::CH_FF: head.kind = tcce_pkg::OP_DOWN;
                    tcce_pkg::CH_TAB:                 head.kind = tcce_pkg::OP_TAB;
                    tcce_pkg::CH_LF:                  head.kind = tcce_pkg::OP_NEWLINE;
                    tcce_pkg::CH_CR:                  head.kind = tcce_pkg::OP_RETURN;
                    default:                          head.kind = tcce_pkg::OP_GLYPH;
                endcase
            end
            tcce_pkg::FUNC_CLEAR: head.kind = tcce_pkg::OP_CLEAR;
            tcce_pkg::FUNC_SET:   head.kind = tcce_pkg::OP_SET;
            tcce_pkg::FUNC_READ:  head.kind = tcce_pkg::OP_READ;
            default:              head.kind = tcce_pkg::OP_READ;
        endcase

        // saturate coordinates at the last column and row
        col_c = (int'(cmd.col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(cmd.col);
        row_c = (int'(cmd.row) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(cmd.row);
    end

    assign push_valid = cmd.valid;
    assign cmd.ready  = push_ready;
    assign push_data  = {head, col_c, row_c};

endmodule

FILE: rtl/core/tcce_queue.sv
// ----------------------------------------------------------------------------
// tcce_queue
// Short FIFO of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
module tcce_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = tcce_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/tcce_back.sv
// ----------------------------------------------------------------------------
// tcce_back
// Executes decoded operations: owns the cursor and the screen RAM, runs the
// tab remainder, scroll copy and fill sequences, and holds the response.
// ----------------------------------------------------------------------------
module tcce_back #(
    parameter int COLUMNS  = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcce_pkg::DEF_ROWS,
    parameter int TAB_STOP = tcce_pkg::DEF_TAB_STOP,
    parameter int COL_W    = $clog2(COLUMNS),
    parameter int ROW_W    = $clog2(ROWS)
) (
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    output logic pop_ready,
    input  logic [$bits(tcce_pkg::op_head_t)+COL_W+ROW_W-1:0] pop_data,
    tcce_rsp_if.source rsp
);

    localparam int HEAD_W    = $bits(tcce_pkg::op_head_t);
    localparam int OP_W      = HEAD_W + COL_W + ROW_W;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int MOVE_N    = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    // cursor may overshoot the screen by a row or a tab before it is folded back
    localparam int LIN_W     = $clog2(CELLS + COLUMNS + TAB_STOP);
    localparam int CUR_COL_W = $clog2(COLUMNS + TAB_STOP);
    localparam int CUR_ROW_W = $clog2(ROWS + 3);
    localparam int REM_W     = $clog2(TAB_STOP);
    // reciprocal of TAB_STOP, exact for every LIN_W-bit cursor
    localparam int RCP_SH    = LIN_W + REM_W;
    localparam int RCP_M     = ((1 << RCP_SH) + TAB_STOP - 1) / TAB_STOP;
    localparam int RCP_W     = $clog2(RCP_M + 1);
    localparam int PROD_W    = LIN_W + RCP_W;
    localparam int CELL_W    = tcce_pkg::CELL_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EXEC   = 8'b0000_0010,
        S_TAB    = 8'b0000_0100,
        S_WRAP   = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_FILL   = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                        state_reg, state_next;
    tcce_pkg::op_head_t            head_reg, head_next;
    logic [COL_W-1:0]              op_col_reg, op_col_next;
    logic [ROW_W-1:0]              op_row_reg, op_row_next;
    logic [CUR_COL_W-1:0]          cur_col_reg, cur_col_next;
    logic [CUR_ROW_W-1:0]          cur_row_reg, cur_row_next;
    logic [LIN_W-1:0]              cur_lin_reg, cur_lin_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [ADDR_W-1:0]             cnt_reg, cnt_next;
    logic                          wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]             wr_addr_reg, wr_addr_next;
    logic                          scrolled_reg, scrolled_next;
    logic [CELL_W-1:0]             cell_reg, cell_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [CELL_W-1:0]             rsp_cell_reg, rsp_cell_next;
    logic [tcce_pkg::COL_PORT_W-1:0] rsp_col_reg, rsp_col_next;
    logic [tcce_pkg::ROW_PORT_W-1:0] rsp_row_reg, rsp_row_next;
    logic                          rsp_scr_reg, rsp_scr_next;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [CELL_W-1:0]             ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [CELL_W-1:0]             ram_rdata;

    logic [CELL_W-1:0]             blank;
    logic [LIN_W-1:0]              op_lin;
    logic [PROD_W-1:0]             tab_prod;
    logic [LIN_W-1:0]              tab_quot;
    logic [REM_W-1:0]              tab_rem;

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop_ready = (state_reg == S_IDLE);

    always_comb
    begin
        blank     = {head_reg.attr, tcce_pkg::BLANK_CHAR};
        op_lin    = LIN_W'(op_row_reg) * LIN_W'(COLUMNS) + LIN_W'(op_col_reg);
        // cursor mod TAB_STOP by reciprocal multiply
        tab_prod  = PROD_W'(cur_lin_reg) * PROD_W'(RCP_M);
        tab_quot  = LIN_W'(tab_prod >> RCP_SH);
        tab_rem   = REM_W'(cur_lin_reg - LIN_W'(tab_quot * LIN_W'(TAB_STOP)));

        state_next     = state_reg;
        head_next      = head_reg;
        op_col_next    = op_col_reg;
        op_row_next    = op_row_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        cur_lin_next   = cur_lin_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        wr_pend_next   = 1'b0;
        wr_addr_next   = wr_addr_reg;
        scrolled_next  = scrolled_reg;
        cell_next      = cell_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_cell_next  = rsp_cell_reg;
        rsp_col_next   = rsp_col_reg;
        rsp_row_next   = rsp_row_reg;
        rsp_scr_next   = rsp_scr_reg;

        // scroll copy: write back the cell read in the previous cycle
        ram_we    = wr_pend_reg;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = op_lin[ADDR_W-1:0];

        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    head_next     = tcce_pkg::op_head_t'(pop_data[OP_W-1 -: HEAD_W]);
                    op_col_next   = pop_data[ROW_W +: COL_W];
                    op_row_next   = pop_data[ROW_W-1:0];
                    scrolled_next = 1'b0;
                    cell_next     = '0;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                unique case (head_reg.kind)
                    tcce_pkg::OP_GLYPH:
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = cur_lin_reg[ADDR_W-1:0];
                        ram_wdata    = {head_reg.attr, head_reg.glyph};
                        cur_lin_next = cur_lin_reg + LIN_W'(1);
                        cur_col_next = cur_col_reg + CUR_COL_W'(1);
                        state_next   = S_WRAP;
                    end
                    tcce_pkg::OP_BACKSPACE:
                    begin
                        if (cur_lin_reg != '0)
                        begin
                            ram_we       = 1'b1;
                            ram_waddr    = ADDR_W'(cur_lin_reg - LIN_W'(1));
                            ram_wdata    = blank;
                            cur_lin_next = cur_lin_reg - LIN_W'(1);
                            if (cur_col_reg == '0)
                            begin
                                cur_col_next = CUR_COL_W'(COLUMNS - 1);
                                cur_row_next = cur_row_reg - CUR_ROW_W'(1);
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg - CUR_COL_W'(1);
                            end
                        end
                        state_next = S_DONE;
                    end
                    tcce_pkg::OP_DOWN:
                    begin
                        cur_lin_next = cur_lin_reg + LIN_W'(COLUMNS);
                        cur_row_next = cur_row_reg + CUR_ROW_W'(1);
                        state_next   = S_WRAP;
                    end
                    tcce_pkg::OP_TAB:
                    begin
                        rem_next   = tab_rem;
                        state_next = S_TAB;
                    end
                    tcce_pkg::OP_NEWLINE:
                    begin
                        cur_lin_next = cur_lin_reg + LIN_W'(COLUMNS) - LIN_W'(cur_col_reg);
                        cur_col_next = '0;
                        cur_row_next = cur_row_reg + CUR_ROW_W'(1);
                        state_next   = S_WRAP;
                    end
                    tcce_pkg::OP_RETURN:
                    begin
                        cur_lin_next = cur_lin_reg - LIN_W'(cur_col_reg);
                        cur_col_next = '0;
                        state_next   = S_DONE;
                    end
                    tcce_pkg::OP_CLEAR:
                    begin
                        cur_lin_next = '0;
                        cur_col_next = '0;
                        cur_row_next = '0;
                        cnt_next     = '0;
                        state_next   = S_FILL;
                    end
                    tcce_pkg::OP_SET:
                    begin
                        cur_lin_next = op_lin;
                        cur_col_next = CUR_COL_W'(op_col_reg);
                        cur_row_next = CUR_ROW_W'(op_row_reg);
                        state_next   = S_DONE;
                    end
                    tcce_pkg::OP_READ:
                    begin
                        ram_raddr  = op_lin[ADDR_W-1:0];
                        state_next = S_READ;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_TAB:
            begin
                cur_lin_next = cur_lin_reg + LIN_W'(TAB_STOP) - LIN_W'(rem_reg);
                cur_col_next = cur_col_reg + CUR_COL_W'(TAB_STOP) - CUR_COL_W'(rem_reg);
                state_next   = S_WRAP;
            end

            S_WRAP:
            begin
                // fold the column back one screen width a cycle, then test for scroll
                if (cur_col_reg >= CUR_COL_W'(COLUMNS))
                begin
                    cur_col_next = cur_col_reg - CUR_COL_W'(COLUMNS);
                    cur_row_next = cur_row_reg + CUR_ROW_W'(1);
                end
                else if (cur_row_reg >= CUR_ROW_W'(ROWS))
                begin
                    cur_row_next  = CUR_ROW_W'(ROWS - 1);
                    cur_lin_next  = LIN_W'(MOVE_N) + LIN_W'(cur_col_reg);
                    scrolled_next = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_SCROLL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_SCROLL:
            begin
                ram_raddr    = cnt_reg + ADDR_W'(COLUMNS);
                wr_pend_next = 1'b1;
                wr_addr_next = cnt_reg;
                if (cnt_reg == ADDR_W'(MOVE_N - 1))
                begin
                    cnt_next   = ADDR_W'(MOVE_N);
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end

            S_FILL:
            begin
                if (!wr_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg;
                    ram_wdata = blank;
                    if (cnt_reg == ADDR_W'(CELLS - 1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + ADDR_W'(1);
                    end
                end
            end

            S_READ:
            begin
                cell_next  = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_cell_next  = cell_reg;
                    rsp_col_next   = tcce_pkg::COL_PORT_W'(cur_col_reg);
                    rsp_row_next   = tcce_pkg::ROW_PORT_W'(cur_row_reg);
                    rsp_scr_next   = scrolled_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            cur_lin_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            cur_lin_reg   <= cur_lin_next;
            wr_pend_reg   <= wr_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg     <= head_next;
        op_col_reg   <= op_col_next;
        op_row_reg   <= op_row_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        wr_addr_reg  <= wr_addr_next;
        scrolled_reg <= scrolled_next;
        cell_reg     <= cell_next;
        rsp_cell_reg <= rsp_cell_next;
        rsp_col_reg  <= rsp_col_next;
        rsp_row_reg  <= rsp_row_next;
        rsp_scr_reg  <= rsp_scr_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cell_data  = rsp_cell_reg;
    assign rsp.cursor_col = rsp_col_reg;
    assign rsp.cursor_row = rsp_row_reg;
    assign rsp.scrolled   = rsp_scr_reg;

endmodule

FILE: rtl/core/text_console_character_engine.sv
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text screen of attribute/character cells with a cursor: put character,
// clear, set cursor and read cell, with scroll on overflow of the last row.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        transaction
//  cmd      in   func char_code back_color fore_color col row   one operation
//  rsp      out  cell_data cursor_col cursor_row scrolled       one result
//
//  After a printable byte, line feed, vertical tab, form feed or tab the
//  cursor column is folded back onto the screen and a scroll is tested for.
//  Scroll and clear write the screen one cell at a time, one RAM write port.
//  Screen RAM is not cleared by reset; cursor resets to the top-left cell.
//  The queue takes up to QUEUE_DEPTH transactions while the back end or rsp stalls.
`include "assert_macros.svh"

module text_console_character_engine #(
    parameter int COLUMNS     = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS        = tcce_pkg::DEF_ROWS,
    parameter int TAB_STOP    = tcce_pkg::DEF_TAB_STOP,
    parameter int QUEUE_DEPTH = tcce_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    tcce_cmd_if.sink   cmd,
    tcce_rsp_if.source rsp
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int OP_W  = $bits(tcce_pkg::op_head_t) + COL_W + ROW_W;

    logic            push_valid, push_ready;
    logic [OP_W-1:0] push_data;
    logic            pop_valid, pop_ready;
    logic [OP_W-1:0] pop_data;

    tcce_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W)
    ) u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tcce_queue #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tcce_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .COL_W    (COL_W),
        .ROW_W    (ROW_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

    `ASSERT_IMPLIES(a_cursor_col_on_screen, rsp.valid, int'(rsp.cursor_col) < COLUMNS)
    `ASSERT_IMPLIES(a_cursor_row_on_screen, rsp.valid, int'(rsp.cursor_row) < ROWS)
    `ASSERT_IMPLIES(a_scroll_leaves_bottom_row, rsp.valid && rsp.scrolled,
                    rsp.cursor_row == tcce_pkg::ROW_PORT_W'(ROWS - 1))
    `ASSERT_NEVER(a_scroll_carries_no_cell,
                  rsp.valid && rsp.scrolled && (rsp.cell_data != '0))

endmodule

FILE: bench/tb_text_console_character_engine.sv
// ----------------------------------------------------------------------------
// tb_text_console_character_engine
// Self-checking bench for the text console engine. A short directed pass
// covers control codes, wrap, scroll and saturation of set and read. About a
// thousand random operations follow, with random gaps on the command side and
// random back-pressure on the response side. A scoreboard keeps its own copy
// of the screen and cursor and checks every response, field by field, in order.
// ----------------------------------------------------------------------------
module tb_text_console_character_engine;
    import tcce_pkg::*;

    localparam int COLS       = DEF_COLUMNS;
    localparam int ROWS       = DEF_ROWS;
    localparam int TAB        = DEF_TAB_STOP;
    localparam int CELLS      = COLS * ROWS;
    localparam int RANDOM_OPS = 1050;
    localparam int DRAIN      = 50;
    // worst case: every op a full-screen rewrite plus both sides' longest waits
    localparam int TIMEOUT_UNITS = 100_000_000;

    typedef struct packed {
        logic [CELL_W-1:0]     cell_data;
        logic [COL_PORT_W-1:0] cursor_col;
        logic [ROW_PORT_W-1:0] cursor_row;
        logic                  scrolled;
    } console_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELLS];
        int                cursor;
        console_result_t   expected_q [$];
        int                mismatches;

        function new();
            cursor     = 0;
            mismatches = 0;
        endfunction

        function int waiting();
            return expected_q.size();
        endfunction

        // works out the response of one accepted command and updates the screen
        function void note_command(func_t f, logic [CHAR_W-1:0] ch,
                                   logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] fg,
                                   logic [COL_PORT_W-1:0] c_in,
                                   logic [ROW_PORT_W-1:0] r_in);
            logic [ATTR_W-1:0] attr;
            logic [CELL_W-1:0] blank;
            console_result_t   res;
            int                c;
            int                r;
            int                idx;
            attr  = {bg, fg};
            blank = {attr, BLANK_CHAR};
            c     = (int'(c_in) > COLS - 1) ? COLS - 1 : int'(c_in);
            r     = (int'(r_in) > ROWS - 1) ? ROWS - 1 : int'(r_in);
            res   = '0;
            case (f)
                FUNC_PUT:
                begin
                    idx = (cursor >= CELLS) ? CELLS - 1 : cursor;
                    case (ch)
                        CH_BS:
                        begin
                            if (idx > 0)
                            begin
                                idx--;
                                screen[idx] = blank;
                            end
                        end
                        CH_VT, CH_FF: idx += COLS;
                        CH_TAB:       idx = idx - (idx % TAB) + TAB;
                        CH_LF:        idx += COLS - (idx % COLS);
                        CH_CR:        idx -= idx % COLS;
                        default:
                        begin
                            screen[idx] = {attr, ch};
                            idx++;
                        end
                    endcase
                    cursor = idx;
                    if (cursor / COLS >= ROWS)
                    begin
                        for (int i = 0; i < (ROWS - 1) * COLS; i++)
                            screen[i] = screen[i + COLS];
                        for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
                            screen[i] = blank;
                        cursor       = (ROWS - 1) * COLS + cursor % COLS;
                        res.scrolled = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    for (int i = 0; i < CELLS; i++)
                        screen[i] = blank;
                    cursor = 0;
                end
                FUNC_SET: cursor = r * COLS + c;
                default:  res.cell_data = screen[r * COLS + c];
            endcase
            res.cursor_col = COL_PORT_W'(cursor % COLS);
            res.cursor_row = ROW_PORT_W'(cursor / COLS);
            expected_q.push_back(res);
        endfunction

        function void check_result(console_result_t got);
            console_result_t exp;
            logic            bad;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with no outstanding command: %s %h %0d %0d %0b",
                             $realtime, "cell col row scr", got.cell_data,
                             got.cursor_col, got.cursor_row, got.scrolled);
                return;
            end
            exp = expected_q.pop_front();
            bad = (got.cell_data !== exp.cell_data) || (got.cursor_col !== exp.cursor_col)
               || (got.cursor_row !== exp.cursor_row) || (got.scrolled !== exp.scrolled);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch: expected cell %h col %0d row %0d scr %0b, ",
                              "got cell %h col %0d row %0d scr %0b"},
                             $realtime, exp.cell_data, exp.cursor_col, exp.cursor_row,
                             exp.scrolled, got.cell_data, got.cursor_col, got.cursor_row,
                             got.scrolled);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    console_scoreboard sb;

    tcce_cmd_if cmd_ch ();
    tcce_rsp_if rsp_ch ();

    text_console_character_engine #(
        .COLUMNS  (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("Simulation FAILED");
        $finish;
    end

    // both channels sampled on the same edge; commands noted before responses
    always @(posedge clk)
    begin : watch_channels
        console_result_t got;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(func_t'(cmd_ch.func), cmd_ch.char_code, cmd_ch.back_color,
                                cmd_ch.fore_color, cmd_ch.col, cmd_ch.row);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.cell_data  = rsp_ch.cell_data;
                got.cursor_col = rsp_ch.cursor_col;
                got.cursor_row = rsp_ch.cursor_row;
                got.scrolled   = rsp_ch.scrolled;
                sb.check_result(got);
            end
        end
    end

    // response back-pressure: fresh stall drawn after every transaction
    initial
    begin : rsp_stall
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    task automatic issue_op(func_t f, logic [CHAR_W-1:0] ch,
                            logic [COLOR_W-1:0] bg, logic [COLOR_W-1:0] fg,
                            logic [COL_PORT_W-1:0] c, logic [ROW_PORT_W-1:0] r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.func       <= f;
        cmd_ch.char_code  <= ch;
        cmd_ch.back_color <= bg;
        cmd_ch.fore_color <= fg;
        cmd_ch.col        <= c;
        cmd_ch.row        <= r;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        issue_op(FUNC_PUT, ch, COLOR_W'($urandom), COLOR_W'($urandom),
                 COL_PORT_W'($urandom), ROW_PORT_W'($urandom));
    endtask

    task automatic set_cursor(int c, int r);
        issue_op(FUNC_SET, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                 COL_PORT_W'(c), ROW_PORT_W'(r));
    endtask

    task automatic read_cell(int c, int r);
        issue_op(FUNC_READ, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                 COL_PORT_W'(c), ROW_PORT_W'(r));
    endtask

    task automatic random_op();
        int                pick;
        int                q;
        int                c;
        int                r;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            issue_op(FUNC_CLEAR, CHAR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     COL_PORT_W'($urandom), ROW_PORT_W'($urandom));
        else if (pick < 12)
        begin
            q = $urandom_range(0, 99);
            c = $urandom_range(0, COLS - 1);
            if (q < 25)
            begin
                c = $urandom_range(0, 127);
                r = $urandom_range(0, 31);
            end
            else if (q < 60)
                r = $urandom_range(ROWS - 5, ROWS - 1);
            else
                r = $urandom_range(0, ROWS - 1);
            set_cursor(c, r);
        end
        else if (pick < 27)
        begin
            q = $urandom_range(0, 99);
            if (q < 20)
            begin
                c = $urandom_range(0, 127);
                r = $urandom_range(0, 31);
            end
            else if (q < 60)
            begin
                // around the cursor, where the recent writes are
                c = $urandom_range(0, COLS - 1);
                r = sb.cursor / COLS;
            end
            else
            begin
                c = $urandom_range(0, COLS - 1);
                r = $urandom_range(0, ROWS - 1);
            end
            read_cell(c, r);
        end
        else
        begin
            q = $urandom_range(0, 99);
            if (q < 55)      ch = CHAR_W'($urandom_range(0, 255));
            else if (q < 70) ch = CH_LF;
            else if (q < 75) ch = CH_VT;
            else if (q < 78) ch = CH_FF;
            else if (q < 86) ch = CH_TAB;
            else if (q < 95) ch = CH_BS;
            else             ch = CH_CR;
            put_char(ch);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        calm              <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= FUNC_PUT;
        cmd_ch.char_code  <= '0;
        cmd_ch.back_color <= '0;
        cmd_ch.fore_color <= '0;
        cmd_ch.col        <= '0;
        cmd_ch.row        <= '0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // screen content is undefined until the first clear: no reads before it
        issue_op(FUNC_PUT, 8'h41, 4'h0, 4'hF, 7'd0, 5'd0);
        set_cursor(127, 31);                 // saturates to the last cell
        issue_op(FUNC_PUT, 8'hFF, 4'hF, 4'h0, 7'd127, 5'd31);   // wraps off the end
        issue_op(FUNC_CLEAR, 8'h00, 4'h1, 4'hE, 7'd0, 5'd0);
        read_cell(0, 0);
        issue_op(FUNC_PUT, 8'h00, 4'hF, 4'hF, 7'd0, 5'd0);
        put_char(CH_BS);
        put_char(CH_BS);                     // already at the origin
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(CH_VT);
        put_char(CH_FF);
        set_cursor(COLS - 1, 0);
        put_char(8'h5A);                     // wraps to the next row
        set_cursor(5, ROWS - 1);
        put_char(CH_LF);
        set_cursor(10, ROWS - 1);
        put_char(CH_VT);
        set_cursor(COLS - 1, ROWS - 1);
        put_char(CH_TAB);
        set_cursor(COLS - 1, ROWS - 1);
        issue_op(FUNC_PUT, 8'h7E, 4'h0, 4'h0, 7'd0, 5'd0);
        read_cell(127, 31);
        read_cell(0, ROWS - 2);

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 64 == 0)
                calm <= ($urandom_range(0, 3) == 0);
            random_op();
        end

        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (sb.mismatches == 0 && sb.waiting() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_cmd_if.sv
rtl/core/tcce_rsp_if.sv
rtl/core/tcce_ram.sv
rtl/core/tcce_front.sv
rtl/core/tcce_queue.sv
rtl/core/tcce_back.sv
rtl/core/text_console_character_engine.sv
bench/tb_text_console_character_engine.sv
